### src/smeu_pkg.sv
package smeu_pkg;

  typedef enum logic [3:0] {
    OP_PUSH        = 4'd0,
    OP_LOAD_STATIC = 4'd1,
    OP_STORE_STATIC = 4'd2,
    OP_ADD         = 4'd3,
    OP_SUB         = 4'd4,
    OP_MUL         = 4'd5,
    OP_DIV         = 4'd6,
    OP_JZ          = 4'd7,
    OP_JNEG        = 4'd8,
    OP_JPOS        = 4'd9,
    OP_STORE_LOCAL = 4'd10,
    OP_LOAD_LOCAL  = 4'd11
  } opcode_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_UNDER  = 3'd1,
    STAT_OVER   = 3'd2,
    STAT_DIVZ   = 3'd3,
    STAT_BADIDX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CALC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  localparam int unsigned WordW = 32;

endpackage

### src/smeu_ram.sv
module smeu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/smeu_slots.sv
module smeu_slots #(
  parameter int unsigned COUNT = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   we_i,
  input  logic [(COUNT > 1 ? $clog2(COUNT) : 1)-1:0] waddr_i,
  input  logic [smeu_pkg::WordW-1:0]             wdata_i,
  input  logic                                   re_i,
  input  logic [(COUNT > 1 ? $clog2(COUNT) : 1)-1:0] raddr_i,
  output logic [smeu_pkg::WordW-1:0]             rdata_o
);

  localparam int unsigned AW = (COUNT > 1) ? $clog2(COUNT) : 1;

  // one written flag per slot; an unwritten slot reads as zero
  logic [(2**AW)-1:0]          written_q;
  logic                        rd_written_q;
  logic [smeu_pkg::WordW-1:0]  ram_rdata;

  smeu_ram #(
    .WIDTH (smeu_pkg::WordW),
    .DEPTH (COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_written_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_written_q ? ram_rdata : '0;

endmodule

### src/smeu_alu.sv
module smeu_alu (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  smeu_pkg::alu_req_t          req_i,
  input  logic [smeu_pkg::WordW-1:0]  a_i,
  input  logic [smeu_pkg::WordW-1:0]  b_i,
  output logic                        done_o,
  output logic [smeu_pkg::WordW-1:0]  result_o
);

  localparam int unsigned W  = smeu_pkg::WordW;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic [W-1:0]  res_q, res_d;
  logic [W:0]    trial;
  logic [W-1:0]  quo_step;

  // one restoring step per cycle on magnitudes, sign fixed at the end
  always_comb begin
    trial    = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    quo_step = {quo_q[W-2:0], ~trial[W]};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    res_d  = res_q;

    if (busy_q) begin
      quo_d = quo_step;
      rem_d = trial[W] ? {rem_q[W-2:0], quo_q[W-1]} : trial[W-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (~quo_step + W'(1)) : quo_step;
      end
    end else if (req_i.start) begin
      unique case (req_i.op)
        smeu_pkg::ALU_ADD: begin
          res_d  = a_i + b_i;
          done_d = 1'b1;
        end
        smeu_pkg::ALU_SUB: begin
          res_d  = a_i - b_i;
          done_d = 1'b1;
        end
        smeu_pkg::ALU_MUL: begin
          res_d  = a_i * b_i;
          done_d = 1'b1;
        end
        smeu_pkg::ALU_DIV: begin
          busy_d = 1'b1;
          cnt_d  = '0;
          neg_d  = a_i[W-1] ^ b_i[W-1];
          rem_d  = '0;
          quo_d  = a_i[W-1] ? (~a_i + W'(1)) : a_i;
          den_d  = b_i[W-1] ? (~b_i + W'(1)) : b_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### src/stack_machine_execute_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o  | opcode_i, operand_i
// out     | output    | out_valid_o / out_stall_i | top_value_o, depth_o, branch_taken_o,
//         |           |                        | branch_target_o, status_o
//
// One instruction at a time: add, sub and mul take one pass through the shared ALU, and div
// runs through it one quotient bit a cycle. The stack memory read is issued at transfer, and
// the push and load write-back comes in the execute state that follows. A new instruction is
// taken while the previous result sits in the output register; a stalled output holds the
// next result back until it drains.
// Reset clears depth, control and the slot written flags; no clearing pass.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH  = 64,
  parameter int unsigned LOCAL_COUNT  = 16,
  parameter int unsigned STATIC_COUNT = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [3:0]                           opcode_i,
  input  logic [31:0]                          operand_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   top_value_o,
  output logic [$clog2(STACK_DEPTH + 1)-1:0]   depth_o,
  output logic                                 branch_taken_o,
  output logic [31:0]                          branch_target_o,
  output logic [2:0]                           status_o
);

  localparam int unsigned W   = smeu_pkg::WordW;
  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int unsigned GAW = (STATIC_COUNT > 1) ? $clog2(STATIC_COUNT) : 1;

  smeu_pkg::state_e  state_q, state_d;
  logic [3:0]        opcode_q;
  logic [W-1:0]      operand_q;
  logic [SPW-1:0]    sp_q, sp_d;
  logic [W-1:0]      tos_q, tos_d;
  smeu_pkg::status_e res_status_q, res_status_d;
  logic              res_taken_q, res_taken_d;
  logic [W-1:0]      res_target_q, res_target_d;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [W-1:0]      out_top_q;
  logic [SPW-1:0]    out_depth_q;
  logic              out_taken_q;
  logic [W-1:0]      out_target_q;
  logic [2:0]        out_status_q;

  logic              transfer;
  logic              out_free;
  logic [SPW-1:0]    sp_m2;
  logic              full, has1, has2, local_ok, static_ok;

  logic              stk_we;
  logic [SAW-1:0]    stk_waddr;
  logic [W-1:0]      stk_wdata;
  logic [W-1:0]      below;
  logic              loc_we, sta_we;
  logic [W-1:0]      loc_rdata, sta_rdata;

  smeu_pkg::alu_req_t alu_req;
  logic               alu_done;
  logic [W-1:0]       alu_result;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == smeu_pkg::S_IDLE) ||
                        ((state_q == smeu_pkg::S_OUT) && out_free));
  assign transfer   = in_valid_i && !in_stall_o;

  assign sp_m2     = sp_q - SPW'(2);
  assign full      = (sp_q == SPW'(STACK_DEPTH));
  assign has1      = (sp_q != '0);
  assign has2      = (sp_q >= SPW'(2));
  assign local_ok  = (operand_q < W'(LOCAL_COUNT));
  assign static_ok = (operand_q < W'(STATIC_COUNT));

  // read of the entry under the top is issued at transfer, used in the execute cycle
  smeu_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (transfer),
    .raddr_i (sp_m2[SAW-1:0]),
    .rdata_o (below)
  );

  smeu_slots #(
    .COUNT (LOCAL_COUNT)
  ) u_locals (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (loc_we),
    .waddr_i (operand_q[LAW-1:0]),
    .wdata_i (tos_q),
    .re_i    (transfer),
    .raddr_i (operand_i[LAW-1:0]),
    .rdata_o (loc_rdata)
  );

  smeu_slots #(
    .COUNT (STATIC_COUNT)
  ) u_statics (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (sta_we),
    .waddr_i (operand_q[GAW-1:0]),
    .wdata_i (tos_q),
    .re_i    (transfer),
    .raddr_i (operand_i[GAW-1:0]),
    .rdata_o (sta_rdata)
  );

  smeu_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (below),
    .b_i      (tos_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    tos_d        = tos_q;
    res_status_d = res_status_q;
    res_taken_d  = res_taken_q;
    res_target_d = res_target_q;
    stk_we       = 1'b0;
    stk_waddr    = sp_q[SAW-1:0];
    stk_wdata    = operand_q;
    loc_we       = 1'b0;
    sta_we       = 1'b0;
    alu_req      = '{start: 1'b0, op: smeu_pkg::ALU_ADD};
    out_load     = 1'b0;

    unique case (state_q)
      smeu_pkg::S_IDLE: begin
        if (transfer) begin
          state_d = smeu_pkg::S_EXEC;
        end
      end

      smeu_pkg::S_EXEC: begin
        res_status_d = smeu_pkg::STAT_OK;
        res_taken_d  = 1'b0;
        res_target_d = '0;
        state_d      = smeu_pkg::S_OUT;
        unique case (opcode_q)
          smeu_pkg::OP_PUSH, smeu_pkg::OP_LOAD_STATIC, smeu_pkg::OP_LOAD_LOCAL: begin
            if (full) begin
              res_status_d = smeu_pkg::STAT_OVER;
            end else if ((opcode_q == smeu_pkg::OP_LOAD_STATIC) && !static_ok) begin
              res_status_d = smeu_pkg::STAT_BADIDX;
            end else if ((opcode_q == smeu_pkg::OP_LOAD_LOCAL) && !local_ok) begin
              res_status_d = smeu_pkg::STAT_BADIDX;
            end else begin
              if (opcode_q == smeu_pkg::OP_LOAD_STATIC) begin
                stk_wdata = sta_rdata;
              end else if (opcode_q == smeu_pkg::OP_LOAD_LOCAL) begin
                stk_wdata = loc_rdata;
              end
              stk_we = 1'b1;
              tos_d  = stk_wdata;
              sp_d   = sp_q + SPW'(1);
            end
          end
          smeu_pkg::OP_STORE_STATIC, smeu_pkg::OP_STORE_LOCAL: begin
            if (!has1) begin
              res_status_d = smeu_pkg::STAT_UNDER;
            end else if ((opcode_q == smeu_pkg::OP_STORE_STATIC) && !static_ok) begin
              res_status_d = smeu_pkg::STAT_BADIDX;
            end else if ((opcode_q == smeu_pkg::OP_STORE_LOCAL) && !local_ok) begin
              res_status_d = smeu_pkg::STAT_BADIDX;
            end else begin
              sta_we = (opcode_q == smeu_pkg::OP_STORE_STATIC);
              loc_we = (opcode_q == smeu_pkg::OP_STORE_LOCAL);
              tos_d  = below;
              sp_d   = sp_q - SPW'(1);
            end
          end
          smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
            if (!has2) begin
              res_status_d = smeu_pkg::STAT_UNDER;
            end else if ((opcode_q == smeu_pkg::OP_DIV) && (tos_q == '0)) begin
              res_status_d = smeu_pkg::STAT_DIVZ;
            end else begin
              alu_req.start = 1'b1;
              unique case (opcode_q)
                smeu_pkg::OP_ADD: alu_req.op = smeu_pkg::ALU_ADD;
                smeu_pkg::OP_SUB: alu_req.op = smeu_pkg::ALU_SUB;
                smeu_pkg::OP_MUL: alu_req.op = smeu_pkg::ALU_MUL;
                default:          alu_req.op = smeu_pkg::ALU_DIV;
              endcase
              state_d = smeu_pkg::S_CALC;
            end
          end
          smeu_pkg::OP_JZ, smeu_pkg::OP_JNEG, smeu_pkg::OP_JPOS: begin
            if (!has1) begin
              res_status_d = smeu_pkg::STAT_UNDER;
            end else begin
              unique case (opcode_q)
                smeu_pkg::OP_JZ:   res_taken_d = (tos_q == '0);
                smeu_pkg::OP_JNEG: res_taken_d = tos_q[W-1];
                default:           res_taken_d = !tos_q[W-1] && (tos_q != '0);
              endcase
              res_target_d = res_taken_d ? operand_q : '0;
              tos_d        = below;
              sp_d         = sp_q - SPW'(1);
            end
          end
          default: ;  // unused opcodes do nothing
        endcase
      end

      smeu_pkg::S_CALC: begin
        // the top two entries collapse into one, written where the lower operand sat
        stk_waddr = sp_m2[SAW-1:0];
        stk_wdata = alu_result;
        if (alu_done) begin
          stk_we  = 1'b1;
          tos_d   = alu_result;
          sp_d    = sp_q - SPW'(1);
          state_d = smeu_pkg::S_OUT;
        end
      end

      smeu_pkg::S_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = transfer ? smeu_pkg::S_EXEC : smeu_pkg::S_IDLE;
        end
      end

      default: state_d = smeu_pkg::S_IDLE;
    endcase

    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smeu_pkg::S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    res_status_q <= res_status_d;
    res_taken_q  <= res_taken_d;
    res_target_q <= res_target_d;
    if (transfer) begin
      opcode_q  <= opcode_i;
      operand_q <= operand_i;
    end
    if (out_load) begin
      out_top_q    <= (sp_q != '0) ? tos_q : '0;
      out_depth_q  <= sp_q;
      out_taken_q  <= res_taken_q;
      out_target_q <= res_target_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign top_value_o     = out_top_q;
  assign depth_o         = out_depth_q;
  assign branch_taken_o  = out_taken_q;
  assign branch_target_o = out_target_q;
  assign status_o        = out_status_q;

endmodule

### sim/tb_stack_machine_execute_unit.sv
`timescale 1ns / 100ps

module tb_stack_machine_execute_unit;

  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned LOCAL_COUNT  = 16;
  localparam int unsigned STATIC_COUNT = 16;
  localparam int unsigned DepthW       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned NumRandom    = 480;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned DrainCycles  = 60;
  localparam logic [3:0]  OpUnusedLo   = 4'd12;
  localparam logic [3:0]  OpUnusedHi   = 4'd15;
  localparam logic [31:0] IntMin       = 32'h8000_0000;
  localparam logic [31:0] IntMax       = 32'h7FFF_FFFF;
  localparam logic [31:0] MinusOne     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0]        top;
    logic [DepthW-1:0]  depth;
    logic               taken;
    logic [31:0]        target;
    smeu_pkg::status_e  status;
  } insn_res_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] word;
    logic        hold;   // wait for all results before presenting
    insn_res_t   res;
  } insn_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [3:0]               opcode_i = '0;
  logic [31:0]              operand_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [31:0]       top_value_o;
  logic [DepthW-1:0]        depth_o;
  logic                     branch_taken_o;
  logic [31:0]              branch_target_o;
  logic [2:0]               status_o;

  // machine state as predicted
  logic [31:0] mdl_stack [STACK_DEPTH];
  logic [31:0] mdl_local [LOCAL_COUNT];
  logic [31:0] mdl_static [STATIC_COUNT];
  int unsigned mdl_sp;

  insn_t       insn_q [$];
  insn_res_t   result_q [$];
  insn_res_t   cur_res;
  int unsigned sent_cnt = 0;
  int unsigned xfer_cnt = 0;
  int unsigned n_err = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_left = 0;

  stack_machine_execute_unit #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_COUNT (LOCAL_COUNT),
    .STATIC_COUNT(STATIC_COUNT)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .operand_i      (operand_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .top_value_o    (top_value_o),
    .depth_o        (depth_o),
    .branch_taken_o (branch_taken_o),
    .branch_target_o(branch_target_o),
    .status_o       (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 0;
  end

  task automatic exec_insn(input logic [3:0] op, input logic [31:0] word,
                           output insn_res_t res);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] v;
    logic        cond;
    res.status = smeu_pkg::STAT_OK;
    res.taken  = 1'b0;
    res.target = '0;
    v = word;
    case (op)
      smeu_pkg::OP_PUSH, smeu_pkg::OP_LOAD_STATIC, smeu_pkg::OP_LOAD_LOCAL: begin
        if (mdl_sp >= STACK_DEPTH) begin
          res.status = smeu_pkg::STAT_OVER;
        end else begin
          if (op == smeu_pkg::OP_LOAD_STATIC) begin
            if (word >= STATIC_COUNT) res.status = smeu_pkg::STAT_BADIDX;
            else v = mdl_static[word[3:0]];
          end else if (op == smeu_pkg::OP_LOAD_LOCAL) begin
            if (word >= LOCAL_COUNT) res.status = smeu_pkg::STAT_BADIDX;
            else v = mdl_local[word[3:0]];
          end
          if (res.status == smeu_pkg::STAT_OK) begin
            mdl_stack[mdl_sp] = v;
            mdl_sp++;
          end
        end
      end
      smeu_pkg::OP_STORE_STATIC, smeu_pkg::OP_STORE_LOCAL: begin
        // stack check comes before the index check
        if (mdl_sp < 1) begin
          res.status = smeu_pkg::STAT_UNDER;
        end else if (op == smeu_pkg::OP_STORE_STATIC) begin
          if (word >= STATIC_COUNT) res.status = smeu_pkg::STAT_BADIDX;
          else mdl_static[word[3:0]] = mdl_stack[mdl_sp-1];
        end else begin
          if (word >= LOCAL_COUNT) res.status = smeu_pkg::STAT_BADIDX;
          else mdl_local[word[3:0]] = mdl_stack[mdl_sp-1];
        end
        if (res.status == smeu_pkg::STAT_OK) mdl_sp--;
      end
      smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV: begin
        if (mdl_sp < 2) begin
          res.status = smeu_pkg::STAT_UNDER;
        end else begin
          a = mdl_stack[mdl_sp-2];
          b = mdl_stack[mdl_sp-1];
          if (op == smeu_pkg::OP_DIV && b == '0) begin
            res.status = smeu_pkg::STAT_DIVZ;
          end else begin
            case (op)
              smeu_pkg::OP_ADD: v = a + b;
              smeu_pkg::OP_SUB: v = a - b;
              smeu_pkg::OP_MUL: v = a * b;
              default: begin
                // most negative over minus one wraps
                if (a == IntMin && b == MinusOne) v = IntMin;
                else v = $signed(a) / $signed(b);
              end
            endcase
            mdl_stack[mdl_sp-2] = v;
            mdl_sp--;
          end
        end
      end
      smeu_pkg::OP_JZ, smeu_pkg::OP_JNEG, smeu_pkg::OP_JPOS: begin
        if (mdl_sp < 1) begin
          res.status = smeu_pkg::STAT_UNDER;
        end else begin
          b = mdl_stack[mdl_sp-1];
          if (op == smeu_pkg::OP_JZ) cond = (b == '0);
          else if (op == smeu_pkg::OP_JNEG) cond = b[31];
          else cond = !b[31] && (b != '0);
          if (cond) begin
            res.taken  = 1'b1;
            res.target = word;
          end
          mdl_sp--;
        end
      end
      default: ;
    endcase
    res.top   = (mdl_sp > 0) ? mdl_stack[mdl_sp-1] : '0;
    res.depth = DepthW'(mdl_sp);
  endtask

  task automatic add_item(input logic [3:0] op, input logic [31:0] word,
                          input logic hold = 1'b0);
    insn_t it;
    it.op   = op;
    it.word = word;
    it.hold = hold;
    exec_insn(op, word, it.res);
    insn_q.insert(insn_q.size(), it);
  endtask

  // push until the stack is full, then one push and two loads that must overflow
  task automatic fill_stack();
    while (mdl_sp < STACK_DEPTH) add_item(smeu_pkg::OP_PUSH, $urandom);
    add_item(smeu_pkg::OP_PUSH, $urandom);
    add_item(smeu_pkg::OP_LOAD_LOCAL, 32'd1);
    add_item(smeu_pkg::OP_LOAD_STATIC, 32'd99);
  endtask

  function automatic int unsigned next_gap();
    int unsigned r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) quiet_left = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return IntMin;
      2:       return IntMax;
      3:       return MinusOne;
      4, 5:    return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_slot();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 15);
    if (r < 90) return 32'd16;
    return $urandom;
  endfunction

  function automatic logic [3:0] rand_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return 4'($urandom_range(OpUnusedLo, OpUnusedHi));
    if (mdl_sp < 2 && r < 60) begin
      case ($urandom_range(0, 3))
        0:       return smeu_pkg::OP_LOAD_STATIC;
        1:       return smeu_pkg::OP_LOAD_LOCAL;
        default: return smeu_pkg::OP_PUSH;
      endcase
    end
    if (mdl_sp > STACK_DEPTH - 8 && r < 60)
      return 4'($urandom_range(smeu_pkg::OP_STORE_STATIC, smeu_pkg::OP_STORE_LOCAL));
    return 4'($urandom_range(smeu_pkg::OP_PUSH, smeu_pkg::OP_LOAD_LOCAL));
  endfunction

  // input driver: change on the falling edge, hold while stalled
  always @(negedge clk_i) begin
    insn_t it;
    if (rst_ni && !(in_valid_i && xfer_cnt != sent_cnt)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (insn_q.size() > 0 && !(insn_q[0].hold && result_q.size() > 0)) begin
        it = insn_q.pop_front();
        opcode_i   <= it.op;
        operand_i  <= it.word;
        in_valid_i <= 1'b1;
        cur_res    = it.res;
        sent_cnt++;
        gap_left   = next_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        stall_left  = $urandom_range(0, 8);
      end else begin
        stall_left = next_gap();
        if (stall_left > 0) begin
          out_stall_i <= 1'b1;
          stall_left--;
        end
      end
    end
  end

  // monitor: input transfers queue their expectation, output transfers are checked
  always @(posedge clk_i) begin
    insn_res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        result_q.insert(result_q.size(), cur_res);
        xfer_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (n_err < MaxReported)
            $display("unexpected result: top=%h depth=%0d status=%0d",
                     top_value_o, depth_o, status_o);
          n_err++;
        end else begin
          want = result_q.pop_front();
          if (top_value_o !== want.top || depth_o !== want.depth ||
              branch_taken_o !== want.taken || branch_target_o !== want.target ||
              status_o !== want.status) begin
            if (n_err < MaxReported) begin
              $display("mismatch: exp top=%h depth=%0d taken=%b target=%h status=%0d",
                       want.top, want.depth, want.taken, want.target, want.status);
              $display("          got top=%h depth=%0d taken=%b target=%h status=%0d",
                       top_value_o, depth_o, branch_taken_o, branch_target_o, status_o);
            end
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    logic [3:0] op;
    logic [31:0] word;
    mdl_sp = 0;
    for (int i = 0; i < STACK_DEPTH; i++) mdl_stack[i] = '0;
    for (int i = 0; i < LOCAL_COUNT; i++) mdl_local[i] = '0;
    for (int i = 0; i < STATIC_COUNT; i++) mdl_static[i] = '0;

    // directed: empty-stack errors, wrap cases, divide corners, jumps, bad indexes, unused opcodes, overflow
    add_item(smeu_pkg::OP_STORE_STATIC, 32'd99);
    add_item(smeu_pkg::OP_ADD, '0);
    add_item(smeu_pkg::OP_JZ, 32'd4);
    add_item(smeu_pkg::OP_LOAD_STATIC, 32'd3);
    add_item(smeu_pkg::OP_LOAD_LOCAL, 32'd16);
    add_item(smeu_pkg::OP_ADD, '0);
    add_item(smeu_pkg::OP_PUSH, IntMax);
    add_item(smeu_pkg::OP_PUSH, 32'd1);
    add_item(smeu_pkg::OP_ADD, '0);
    add_item(smeu_pkg::OP_PUSH, MinusOne);
    add_item(smeu_pkg::OP_DIV, '0);
    add_item(smeu_pkg::OP_PUSH, '0);
    add_item(smeu_pkg::OP_DIV, '0);
    add_item(smeu_pkg::OP_JZ, MinusOne);
    add_item(smeu_pkg::OP_JNEG, 32'd5);
    add_item(smeu_pkg::OP_JPOS, 32'd7);
    add_item(smeu_pkg::OP_PUSH, 32'd7);
    add_item(smeu_pkg::OP_PUSH, 32'hFFFF_FFFE);
    add_item(smeu_pkg::OP_DIV, '0);
    add_item(smeu_pkg::OP_PUSH, IntMax);
    add_item(smeu_pkg::OP_MUL, '0);
    add_item(smeu_pkg::OP_PUSH, IntMin);
    add_item(smeu_pkg::OP_SUB, '0);
    add_item(smeu_pkg::OP_JPOS, 32'hDEAD_BEEF);
    add_item(smeu_pkg::OP_PUSH, 32'd42);
    add_item(smeu_pkg::OP_STORE_STATIC, 32'd16);
    add_item(smeu_pkg::OP_STORE_STATIC, 32'd15);
    add_item(smeu_pkg::OP_LOAD_STATIC, 32'd15);
    add_item(smeu_pkg::OP_STORE_LOCAL, IntMin);
    add_item(smeu_pkg::OP_STORE_LOCAL, 32'd0);
    add_item(smeu_pkg::OP_LOAD_LOCAL, 32'd0);
    add_item(OpUnusedLo, MinusOne);
    add_item(OpUnusedHi, '0);
    fill_stack();

    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 299) == 0) fill_stack();
      op = rand_op();
      case (op)
        smeu_pkg::OP_PUSH:                                 word = rand_imm();
        smeu_pkg::OP_LOAD_STATIC, smeu_pkg::OP_LOAD_LOCAL,
        smeu_pkg::OP_STORE_STATIC, smeu_pkg::OP_STORE_LOCAL: word = rand_slot();
        default:                                           word = $urandom;
      endcase
      add_item(op, word, (i % 150) == 0);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (insn_q.size() > 0 || sent_cnt != xfer_cnt || result_q.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_err == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
